// ----- design/nec_pkg.sv -----
// Shared constants for the nested envelope chain length block.
package nec_pkg;

    localparam int FIELD_W   = 16;
    localparam int CHAIN_W   = 9;
    localparam int CHAIN_MAX = 511;

    localparam int IN_TDATA_W  = 2 * FIELD_W;
    localparam int OUT_TDATA_W = ((CHAIN_W + 7) / 8) * 8;

    // Sequencer state codes.
    localparam int ST_W       = 3;
    localparam logic [ST_W-1:0] ST_LOAD    = 3'd0;
    localparam logic [ST_W-1:0] ST_SORT_I  = 3'd1;
    localparam logic [ST_W-1:0] ST_SORT_LD = 3'd2;
    localparam logic [ST_W-1:0] ST_SORT_CM = 3'd3;
    localparam logic [ST_W-1:0] ST_CH_I    = 3'd4;
    localparam logic [ST_W-1:0] ST_CH_LD   = 3'd5;
    localparam logic [ST_W-1:0] ST_CH_CM   = 3'd6;
    localparam logic [ST_W-1:0] ST_DONE    = 3'd7;

endpackage

// ----- design/nec_mem.sv -----
// Single-port-write, single-port-read synchronous envelope memory.
module nec_mem
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 41
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/nested_envelope_chain_length.sv -----
// Top level: envelope loader, in-memory insertion sort and chain pass.
//
//  channel | dir | handshake               | payload
//  s_*     | in  | s_tvalid / s_tready     | s_tdata {width, height}, s_tlast = last
//  m_*     | out | m_tvalid / m_tready     | m_tdata {chain_length}, m_tuser = overflow
//
// Loading takes one envelope per cycle while s_tready is high.
// After the last envelope the set of n entries is sorted in the envelope memory
// and the chain pass reads it again; both are bound by the single memory read port.
// s_tready stays low from the last envelope until the result is taken.
// Reset clears the fill count, overflow flag and sequencer; memory is not cleared.
module nested_envelope_chain_length
    import nec_pkg::*;
#(
    parameter int MAX_ITEMS = 256,
    parameter int DIM_BITS  = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] height, [31:16] width
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [8:0] chain_length, rest zero
    output logic                   m_tuser    // [0] overflow
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int DW = 2 * DIM_BITS + CW;

    logic [ST_W-1:0]     state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [DIM_BITS-1:0] h_reg, h_next;
    logic [DIM_BITS-1:0] w_reg, w_next;
    logic [CW-1:0]       len_reg, len_next;
    logic [CW-1:0]       best_reg, best_next;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [DW-1:0]       wr_data;
    logic [AW-1:0]       rd_addr;
    logic [DW-1:0]       rd_data;

    logic [DIM_BITS-1:0] rd_h, rd_w;
    logic [CW-1:0]       rd_len;
    logic [DIM_BITS-1:0] in_h, in_w;
    logic [31:0]         in_h32, in_w32, best32;
    logic [CW-1:0]       jm1;
    logic                ahead, smaller;

    nec_mem #(.DEPTH(MAX_ITEMS), .AW(AW), .DW(DW)) u_mem
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_h   = rd_data[DW-1 -: DIM_BITS];
    assign rd_w   = rd_data[CW +: DIM_BITS];
    assign rd_len = rd_data[CW-1:0];

    assign in_h32 = 32'(s_tdata[FIELD_W-1:0]);
    assign in_w32 = 32'(s_tdata[2*FIELD_W-1:FIELD_W]);
    assign in_h   = in_h32[DIM_BITS-1:0];
    assign in_w   = in_w32[DIM_BITS-1:0];

    assign jm1     = j_reg - CW'(1);
    assign ahead   = (h_reg == rd_h) ? (w_reg < rd_w) : (h_reg < rd_h);
    assign smaller = (rd_h < h_reg) && (rd_w < w_reg);

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_DONE);
    assign m_tuser  = ovf_reg;
    assign best32   = 32'(best_reg);
    assign m_tdata  = OUT_TDATA_W'((best32 > 32'(CHAIN_MAX)) ? 32'(CHAIN_MAX) : best32);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        h_next     = h_reg;
        w_next     = w_reg;
        len_next   = len_reg;
        best_next  = best_reg;
        wr_en      = 1'b0;
        wr_addr    = cnt_reg[AW-1:0];
        wr_data    = {in_h, in_w, CW'(0)};
        rd_addr    = i_reg[AW-1:0];

        case (state_reg)
            ST_LOAD:
            begin
                if (s_tvalid)
                begin
                    if (cnt_reg < CW'(MAX_ITEMS))
                    begin
                        wr_en    = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        i_next     = CW'(1);
                        state_next = ST_SORT_I;
                    end
                end
            end
            ST_SORT_I:
            begin
                if (i_reg >= cnt_reg)
                begin
                    i_next     = '0;
                    best_next  = CW'(1);
                    state_next = ST_CH_I;
                end
                else
                begin
                    rd_addr    = i_reg[AW-1:0];
                    state_next = ST_SORT_LD;
                end
            end
            ST_SORT_LD:
            begin
                // hold the entry being inserted, fetch its left neighbor
                h_next     = rd_h;
                w_next     = rd_w;
                j_next     = i_reg;
                rd_addr    = AW'(i_reg - CW'(1));
                state_next = ST_SORT_CM;
            end
            ST_SORT_CM:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg[AW-1:0];
                if ((j_reg != '0) && ahead)
                begin
                    // shift the neighbor right and keep walking left
                    wr_data = rd_data;
                    j_next  = jm1;
                    rd_addr = AW'(jm1 - CW'(1));
                end
                else
                begin
                    wr_data    = {h_reg, w_reg, CW'(0)};
                    i_next     = i_reg + CW'(1);
                    state_next = ST_SORT_I;
                end
            end
            ST_CH_I:
            begin
                if (i_reg >= cnt_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_addr    = i_reg[AW-1:0];
                    state_next = ST_CH_LD;
                end
            end
            ST_CH_LD:
            begin
                h_next     = rd_h;
                w_next     = rd_w;
                len_next   = CW'(1);
                j_next     = '0;
                rd_addr    = '0;
                state_next = ST_CH_CM;
            end
            ST_CH_CM:
            begin
                if (j_reg < i_reg)
                begin
                    if (smaller && ((rd_len + CW'(1)) > len_reg))
                    begin
                        len_next = rd_len + CW'(1);
                    end
                    j_next  = j_reg + CW'(1);
                    rd_addr = AW'(j_reg + CW'(1));
                end
                else
                begin
                    // write back this entry's chain and advance
                    wr_en   = 1'b1;
                    wr_addr = i_reg[AW-1:0];
                    wr_data = {h_reg, w_reg, len_reg};
                    if (len_reg > best_reg)
                    begin
                        best_next = len_reg;
                    end
                    i_next     = i_reg + CW'(1);
                    state_next = ST_CH_I;
                end
            end
            ST_DONE:
            begin
                if (m_tready)
                begin
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg    <= h_next;
        w_reg    <= w_next;
        len_reg  <= len_next;
        best_reg <= best_next;
    end

endmodule

// ----- test/testbench.sv -----
// Testbench for the nested envelope chain length block: directed and random envelope sets.
module testbench;
    import nec_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY  = 256;
    localparam int CYCLE_CAP = 2000000;

    typedef struct packed {
        logic [CHAIN_W-1:0] chain_length;
        logic               overflow;
    } chain_result_t;

    class chain_scoreboard;
        logic [FIELD_W-1:0] env_h[$];
        logic [FIELD_W-1:0] env_w[$];
        bit                 dropped;
        chain_result_t      pending[$];
        int                 errors;

        function void note_envelope(logic [FIELD_W-1:0] h, logic [FIELD_W-1:0] w, logic lst);
            int n;
            int best;
            int len[$];
            logic [FIELD_W-1:0] th;
            logic [FIELD_W-1:0] tw;
            chain_result_t r;
            if (env_h.size() < CAPACITY)
            begin
                env_h.push_back(h);
                env_w.push_back(w);
            end
            else
                dropped = 1;
            if (!lst)
                return;
            n = env_h.size();
            // order by height, then width
            for (int i = 1; i < n; i++)
                for (int j = i; j > 0; j--)
                    if (env_h[j] < env_h[j-1] ||
                        (env_h[j] == env_h[j-1] && env_w[j] < env_w[j-1]))
                    begin
                        th = env_h[j]; env_h[j] = env_h[j-1]; env_h[j-1] = th;
                        tw = env_w[j]; env_w[j] = env_w[j-1]; env_w[j-1] = tw;
                    end
            best = 1;
            for (int i = 0; i < n; i++)
            begin
                len.push_back(1);
                for (int j = 0; j < i; j++)
                    if (env_h[j] < env_h[i] && env_w[j] < env_w[i] && len[j] + 1 > len[i])
                        len[i] = len[j] + 1;
                if (len[i] > best)
                    best = len[i];
            end
            if (best > CHAIN_MAX)
                best = CHAIN_MAX;
            r.chain_length = CHAIN_W'(best);
            r.overflow     = dropped;
            pending.push_back(r);
            env_h.delete();
            env_w.delete();
            dropped = 0;
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, logic usr);
            chain_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result chain_length=%0d", data[CHAIN_W-1:0]);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[CHAIN_W-1:0] !== e.chain_length)
            begin
                $error("chain_length expected %0d actual %0d", e.chain_length, data[CHAIN_W-1:0]);
                errors++;
            end
            if (usr !== e.overflow)
            begin
                $error("overflow expected %0d actual %0d", e.overflow, usr);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // [15:0] height, [31:16] width
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [8:0] chain_length, rest zero
    logic                   m_tuser;   // [0] overflow

    chain_scoreboard board;
    int              send_idle;
    int              recv_idle;
    int              cycles;

    nested_envelope_chain_length dut (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: check results and stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 0;
        else
        begin
            if (m_tvalid && m_tready)
                board.check_result(m_tdata, m_tuser);
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_envelope(logic [FIELD_W-1:0] h, logic [FIELD_W-1:0] w, logic lst);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {w, h};
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_envelope(h, w, lst);
    endtask

    task automatic send_set(int n, int mode);
        logic [FIELD_W-1:0] h;
        logic [FIELD_W-1:0] w;
        for (int i = 0; i < n; i++)
        begin
            case (mode)
                0: begin h = FIELD_W'($urandom); w = FIELD_W'($urandom); end
                1: begin h = FIELD_W'($urandom_range(15)); w = FIELD_W'($urandom_range(15)); end
                default:
                begin
                    h = FIELD_W'(i * 3 + $urandom_range(2));
                    w = FIELD_W'(i * 5 + $urandom_range(4));
                end
            endcase
            send_envelope(h, w, i == n - 1);
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        board     = new();
        rst_n     = 0;
        s_tvalid  = 0;
        s_tdata   = '0;
        s_tlast   = 0;
        send_idle = 0;
        recv_idle = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: single, extremes, equal, nested, ties
        send_envelope(16'h0000, 16'h0000, 1);
        send_envelope(16'hFFFF, 16'hFFFF, 1);
        send_envelope(16'h0000, 16'h0000, 0);
        send_envelope(16'hFFFF, 16'hFFFF, 1);
        send_envelope(16'h5555, 16'hAAAA, 0);
        send_envelope(16'hAAAA, 16'h5555, 1);
        send_envelope(5, 5, 0);
        send_envelope(5, 5, 0);
        send_envelope(5, 6, 0);
        send_envelope(6, 5, 1);
        send_envelope(4, 1, 0);
        send_envelope(3, 2, 0);
        send_envelope(2, 3, 0);
        send_envelope(1, 4, 1);
        drain();
        // buffer full: fully nested set past capacity, dropped last three items
        send_set(CAPACITY + 3, 2);
        drain();
        send_set(CAPACITY, 2);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 35 : (phase == 1) ? 61 : 0;
            recv_idle = (phase == 0) ? 61 : (phase == 1) ? 35 : 0;
            for (int k = 0; k < 45; k++)
            begin
                int n;
                n = ($urandom_range(9) == 0) ? $urandom_range(60, 2) : $urandom_range(12, 1);
                send_set(n, $urandom_range(2));
            end
            // hold off until every result is in
            drain();
        end

        drain();
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
design/nec_pkg.sv
design/nec_mem.sv
design/nested_envelope_chain_length.sv
test/testbench.sv
